[src/integer_to_radix_text_core_defines.svh]
// ----------------------------------------------------------------------------
// Integer to radix text: assertion macros
// Shared assertion forms, clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_TEXT_CORE_DEFINES_SVH
`define INTEGER_TO_RADIX_TEXT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/itrt_pkg.sv]
// ----------------------------------------------------------------------------
// Integer to radix text package
// Widths, register codes, character constants and the job record that the
// front end hands to the conversion engine.
// ----------------------------------------------------------------------------
package itrt_pkg;

  // Input value and digit storage.
  localparam int VALUE_W    = 64;
  localparam int MAX_DIGITS = 64;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_W);

  // Base and digit widths.
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // Job queue between front end and engine.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Base limits and reset values.
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_MINUS     = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_ZERO      = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_UPPER_OFS = CHAR_W'(55);
  localparam logic [CHAR_W-1:0] CHAR_LOWER_OFS = CHAR_W'(87);
  localparam logic [DIGIT_W-1:0] DIGIT_NINE    = DIGIT_W'(9);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX = 1'b0,
    REG_UPPER = 1'b1
  } cfg_reg_e;

  // Conversion engine states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_SIGN,
    S_FETCH,
    S_EMIT
  } back_state_e;

  // One classified item, ready for conversion.
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [RADIX_W-1:0] radix;
    logic               upper;
  } job_t;

  // Map one digit to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d,
                                                      input logic upper);
    logic [CHAR_W-1:0] ofs;
    if (d <= DIGIT_NINE) begin
      ofs = CHAR_ZERO;
    end else if (upper) begin
      ofs = CHAR_UPPER_OFS;
    end else begin
      ofs = CHAR_LOWER_OFS;
    end
    return ofs + CHAR_W'(d);
  endfunction

endpackage

[src/integer_to_radix_text_core.sv]
// ----------------------------------------------------------------------------
// Integer to radix text core
// Converts signed 64-bit integers to ASCII text in a configured base.
// ----------------------------------------------------------------------------
// Each accepted value comes out as a run of ASCII characters, one per output
// transfer, most significant digit first, with a leading minus sign for
// negative values, a single '0' for zero, and last set on the final character.
// The most negative input is converted as if it were one larger. Every digit
// is produced on the engine's radix-2 serial divider (64 shift-subtract
// steps and one store), and every character is then fetched from the digit
// store in S_FETCH and presented in S_EMIT, the sign in S_SIGN; an output
// stall holds the engine in S_SIGN or S_EMIT. A two-entry job queue in front
// of the engine lets two more values be accepted while it is busy. Configuration
// writes take effect for values accepted after them and should be made while
// idle.
// ----------------------------------------------------------------------------
module integer_to_radix_text_core
  import itrt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [CHAR_W-1:0]         char_code_o,
  output logic                      last_o
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  // Front end: configuration and classification.
  itrt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // Job queue between the two halves.
  itrt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // Conversion engine and character output.
  itrt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

[src/itrt_front.sv]
// ----------------------------------------------------------------------------
// Integer to radix text: front end
// Holds the configuration registers and turns each incoming value into a job:
// saturated, split into sign and magnitude, with the base clamped to range.
// ----------------------------------------------------------------------------
module itrt_front
  import itrt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output job_t                  push_job_o
);

  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  logic [RADIX_W-1:0] radix_q;
  logic               upper_q;
  logic [VALUE_W-1:0] val_u;
  logic [VALUE_W-1:0] val_sat;
  logic [RADIX_W-1:0] radix_eff;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
      upper_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RADIX: radix_q <= cfg_data_i[RADIX_W-1:0];
        REG_UPPER: upper_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Saturate the most negative value; the job record below takes sign and magnitude.
  always_comb begin
    val_u   = $unsigned(value_i);
    val_sat = (val_u == VALUE_MIN) ? (VALUE_MIN + VALUE_W'(1)) : val_u;
  end

  // Clamp the base into the supported range.
  always_comb begin
    if (radix_q < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_q;
    end
  end

  // Job record toward the queue.
  always_comb begin
    push_job_o.neg   = val_sat[VALUE_W-1];
    push_job_o.mag   = val_sat[VALUE_W-1] ? (~val_sat + VALUE_W'(1)) : val_sat;
    push_job_o.radix = radix_eff;
    push_job_o.upper = upper_q;
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

[src/itrt_queue.sv]
// ----------------------------------------------------------------------------
// Integer to radix text: job queue
// Short FIFO of classified jobs so the front end can take new values while
// the engine is still converting.
// ----------------------------------------------------------------------------
module itrt_queue
  import itrt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  job_t              slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = slots_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

[src/itrt_back.sv]
// ----------------------------------------------------------------------------
// Integer to radix text: conversion engine
// Divides the magnitude by the base on a radix-2 serial divider, storing one
// digit per pass, then sends the sign and the digits most significant first.
// ----------------------------------------------------------------------------
`include "integer_to_radix_text_core_defines.svh"

module itrt_back
  import itrt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  job_t              job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] char_code_o,
  output logic              last_o
);

  back_state_e state_q, state_d;

  logic [VALUE_W-1:0]   mag_q, mag_d;
  logic [DIGIT_W-1:0]   rem_q, rem_d;
  logic                 neg_q, neg_d;
  logic [RADIX_W-1:0]   radix_q, radix_d;
  logic                 upper_q, upper_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [IDX_W-1:0]     idx_q, idx_d;

  logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_q;
  logic               rd_en;
  logic               wr_en;

  logic [DIGIT_W:0]   rem_shift;
  logic               take;
  logic [DIGIT_W:0]   rem_sub;
  logic [CNT_W-1:0]   count_inc;
  logic [CNT_W-1:0]   cap;
  logic               digits_done;

  // One restoring division step: shift in the next dividend bit and subtract.
  always_comb begin
    rem_shift = {rem_q, mag_q[VALUE_W-1]};
    take      = (rem_shift >= {1'b0, radix_q});
    rem_sub   = take ? (rem_shift - {1'b0, radix_q}) : rem_shift;
  end

  // Digit capacity leaves room for the sign.
  always_comb begin
    count_inc   = count_q + 1'b1;
    cap         = CNT_W'(MAX_DIGITS) - CNT_W'(neg_q);
    digits_done = (mag_q == '0) || (count_inc == cap);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) state_d = S_DIV;
      end
      S_DIV: begin
        if (bit_cnt_q == BIT_CNT_W'(VALUE_W - 1)) state_d = S_STORE;
      end
      S_STORE: begin
        if (digits_done) begin
          state_d = neg_q ? S_SIGN : S_FETCH;
        end else begin
          state_d = S_DIV;
        end
      end
      S_SIGN: begin
        if (out_ready_i) state_d = S_FETCH;
      end
      S_FETCH: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) state_d = (idx_q == '0) ? S_IDLE : S_FETCH;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    job_ready_o = (state_q == S_IDLE);
    out_valid_o = (state_q == S_SIGN) || (state_q == S_EMIT);
    char_code_o = (state_q == S_SIGN) ? CHAR_MINUS : digit_to_char(rd_data_q, upper_q);
    last_o      = (state_q == S_EMIT) && (idx_q == '0);
    rd_en       = (state_q == S_FETCH);
    wr_en       = (state_q == S_STORE);
  end

  // Datapath next values.
  always_comb begin
    mag_d     = mag_q;
    rem_d     = rem_q;
    neg_d     = neg_q;
    radix_d   = radix_q;
    upper_d   = upper_q;
    count_d   = count_q;
    bit_cnt_d = bit_cnt_q;
    idx_d     = idx_q;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          mag_d     = job_i.mag;
          neg_d     = job_i.neg;
          radix_d   = job_i.radix;
          upper_d   = job_i.upper;
          rem_d     = '0;
          count_d   = '0;
          bit_cnt_d = '0;
        end
      end
      S_DIV: begin
        mag_d     = {mag_q[VALUE_W-2:0], take};
        rem_d     = rem_sub[DIGIT_W-1:0];
        bit_cnt_d = bit_cnt_q + 1'b1;
      end
      S_STORE: begin
        count_d = count_inc;
        rem_d   = '0;
        idx_d   = count_q[IDX_W-1:0];
      end
      S_EMIT: begin
        if (out_ready_i && (idx_q != '0)) idx_d = idx_q - 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      bit_cnt_q <= '0;
      idx_q     <= '0;
      neg_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      bit_cnt_q <= bit_cnt_d;
      idx_q     <= idx_d;
      neg_q     <= neg_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    upper_q <= upper_d;
  end

  // Digit store: written least significant first, read back in reverse.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      digit_mem[count_q[IDX_W-1:0]] <= rem_q;
    end
    if (rd_en) begin
      rd_data_q <= digit_mem[idx_q];
    end
  end

  `ITRT_ASSERT_IMP(a_rem_below_radix, state_q == S_DIV, rem_q < radix_q, "remainder reached the base")
  `ITRT_ASSERT_IMP(a_count_in_cap, state_q == S_STORE, count_inc <= cap, "digit count passed capacity")
  `ITRT_ASSERT_NXT(a_zero_quotient_ends, (state_q == S_STORE) && (mag_q == '0), state_q != S_DIV, "division went on after a zero quotient")
  `ITRT_ASSERT_NXT(a_job_starts_clean, (state_q == S_IDLE) && job_valid_i, (state_q == S_DIV) && (bit_cnt_q == '0) && (count_q == '0), "job did not start a fresh division")

endmodule
